// ===== rtl/rvd_pkg.sv =====
package rvd_pkg;

    localparam int SEG_CNT_W   = 7;
    localparam int QUEUE_DEPTH = 4;

    localparam logic [15:0] MIN_PACKET   = 16'd20;
    localparam logic [15:0] HEADER_START = 16'd14;

    localparam logic [1:0] KIND_WRITE = 2'd0;
    localparam logic [1:0] KIND_FRAME = 2'd1;
    localparam logic [1:0] KIND_EOS   = 2'd2;

    localparam logic REG_LINE_STRIDE = 1'b0;

    typedef enum logic [2:0] {
        HP_LEN_HI,
        HP_LEN_LO,
        HP_LINE_HI,
        HP_LINE_LO,
        HP_OFF_HI,
        HP_OFF_LO
    } hdr_pos_t;

    typedef enum logic [2:0] {
        BK_RUN,
        BK_OPEN_RD,
        BK_OPEN_MUL,
        BK_OPEN_CHK,
        BK_EOP
    } back_state_t;

    typedef struct packed {
        logic [15:0] len;
        logic [14:0] line;
        logic [14:0] off;
    } seg_entry_t;

    typedef struct packed {
        logic                 eos;
        logic                 clear;
        logic                 ts_check;
        logic [31:0]          ts;
        logic                 open;
        logic                 payload;
        logic [7:0]           data;
        logic                 eop;
        logic [15:0]          next_off;
        logic [15:0]          plen;
        logic [SEG_CNT_W-1:0] count;
    } seg_op_t;

    typedef struct packed {
        logic [1:0]  kind;
        logic [22:0] addr;
        logic [7:0]  data;
        logic [30:0] size;
        logic [31:0] ts;
        logic        last;
    } result_t;

endpackage

// ===== rtl/rvd_if.sv =====
interface rvd_byte_if;
    logic        valid;
    logic        ready;
    logic        kind;
    logic [7:0]  data_byte;
    logic [15:0] packet_length;

    modport source (output valid, kind, data_byte, packet_length, input ready);
    modport sink (input valid, kind, data_byte, packet_length, output ready);
endinterface

interface rvd_result_if;
    logic        valid;
    logic        ready;
    logic [1:0]  kind_res;
    logic [22:0] write_address;
    logic [7:0]  write_data;
    logic [30:0] frame_size;
    logic [31:0] frame_timestamp;
    logic        last_of_run;

    modport source (output valid, kind_res, write_address, write_data, frame_size,
                    frame_timestamp, last_of_run, input ready);
    modport sink (input valid, kind_res, write_address, write_data, frame_size,
                  frame_timestamp, last_of_run, output ready);
endinterface

// ===== rtl/rvd_ram.sv =====
module rvd_ram #(
    parameter int WIDTH = 46,
    parameter int DEPTH = 32,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
)(
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/rvd_queue.sv =====
module rvd_queue
    import rvd_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    push_valid,
    output logic    push_ready,
    input  seg_op_t push_op,
    output logic    pop_valid,
    input  logic    pop_ready,
    output seg_op_t pop_op
);

    localparam int PW = $clog2(QUEUE_DEPTH);

    seg_op_t       slots [QUEUE_DEPTH];
    logic [PW-1:0] wr_ptr_reg;
    logic [PW-1:0] rd_ptr_reg;
    logic [PW:0]   fill_reg;
    logic          do_push;
    logic          do_pop;

    assign push_ready = (fill_reg != (PW + 1)'(QUEUE_DEPTH));
    assign pop_valid  = (fill_reg != '0);
    assign pop_op     = slots[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            if (do_push)
            begin
                wr_ptr_reg <= wr_ptr_reg + 1'b1;
            end
            if (do_pop)
            begin
                rd_ptr_reg <= rd_ptr_reg + 1'b1;
            end
            if (do_push && !do_pop)
            begin
                fill_reg <= fill_reg + 1'b1;
            end
            else if (do_pop && !do_push)
            begin
                fill_reg <= fill_reg - 1'b1;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            slots[wr_ptr_reg] <= push_op;
        end
    end

endmodule

// ===== rtl/rvd_front.sv =====
module rvd_front
    import rvd_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32,
    localparam int IDXW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
)(
    input  logic            clk,
    input  logic            rst_n,
    rvd_byte_if.sink        byte_ch,
    output logic            push_valid,
    input  logic            push_ready,
    output seg_op_t         push_op,
    output logic            tbl_we,
    output logic [IDXW-1:0] tbl_waddr,
    output seg_entry_t      tbl_wdata
);

    logic [15:0] bidx_reg, bidx_next;
    hdr_pos_t    pos_reg, pos_next;
    logic        mk_reg, mk_next;
    logic [31:0] ts_reg, ts_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic        done_reg, done_next;
    logic        pend_reg, pend_next;
    seg_entry_t  ent_reg, ent_next;
    seg_op_t     op;
    logic        we;
    logic        accept;

    assign accept        = byte_ch.valid && push_ready;
    assign byte_ch.ready = push_ready;
    assign push_valid    = byte_ch.valid;
    assign push_op       = op;
    assign tbl_we        = we && accept;
    assign tbl_wdata     = ent_next;
    assign tbl_waddr     = (cnt_next == '0) ? '0 : IDXW'(cnt_next - 1'b1);

    always_comb
    begin
        logic [15:0] b;
        logic [15:0] plen;
        logic [7:0]  d;
        logic        first;
        logic        big;
        logic        end_pkt;
        b       = bidx_reg;
        plen    = byte_ch.packet_length;
        d       = byte_ch.data_byte;
        first   = (b == 16'd0);
        big     = (plen >= MIN_PACKET);
        end_pkt = ({1'b0, b} + 17'd1) >= {1'b0, plen};

        mk_next   = first ? 1'b0 : mk_reg;
        ts_next   = first ? 32'd0 : ts_reg;
        cnt_next  = first ? '0 : cnt_reg;
        done_next = first ? 1'b0 : done_reg;
        pend_next = 1'b0;
        ent_next  = ent_reg;
        we        = 1'b0;
        op        = '0;

        if (big && (b == 16'd1))
        begin
            mk_next = d[7];
        end
        if (big && (b >= 16'd4) && (b <= 16'd7))
        begin
            ts_next = {ts_next[23:0], d};
        end
        if (big && (b == 16'd7))
        begin
            op.ts_check = 1'b1;
        end

        if (big && (b >= HEADER_START) && !done_next)
        begin
            we = 1'b1;
            unique case (pos_reg)
                HP_LEN_HI:
                begin
                    if (cnt_next < CW'(MAX_SEGMENTS))
                    begin
                        ent_next = '{len: {d, 8'h00}, line: 15'd0, off: 15'd0};
                        cnt_next = cnt_next + 1'b1;
                    end
                    else
                    begin
                        ent_next.len = {d, 8'h00};
                    end
                end
                HP_LEN_LO:  ent_next.len  = ent_next.len | {8'h00, d};
                HP_LINE_HI: ent_next.line = {d[6:0], 8'h00};
                HP_LINE_LO: ent_next.line = ent_next.line | {7'h00, d};
                HP_OFF_HI:
                begin
                    ent_next.off = {d[6:0], 8'h00};
                    if (!d[7])
                    begin
                        done_next = 1'b1;
                        pend_next = 1'b1;
                    end
                end
                HP_OFF_LO:
                begin
                    ent_next.off = ent_next.off | {7'h00, d};
                    if ((cnt_next >= CW'(MAX_SEGMENTS)) ||
                        (({1'b0, b} + 17'd7) > {1'b0, plen}))
                    begin
                        done_next = 1'b1;
                        op.open   = 1'b1;
                    end
                end
                default: we = 1'b0;
            endcase
        end
        else if (big && (b >= HEADER_START))
        begin
            if (pend_reg)
            begin
                ent_next.off = ent_next.off | {7'h00, d};
                we           = 1'b1;
                op.open      = 1'b1;
            end
            else
            begin
                op.payload = 1'b1;
            end
        end

        op.clear    = first;
        op.ts       = ts_next;
        op.data     = d;
        op.eop      = end_pkt && big && mk_next;
        op.next_off = b + 16'd1;
        op.plen     = plen;
        op.count    = SEG_CNT_W'(cnt_next);

        bidx_next = end_pkt ? 16'd0 : (b + 16'd1);

        if (b == (HEADER_START - 16'd1))
        begin
            pos_next = HP_LEN_HI;
        end
        else if (b >= HEADER_START)
        begin
            unique case (pos_reg)
                HP_LEN_HI:  pos_next = HP_LEN_LO;
                HP_LEN_LO:  pos_next = HP_LINE_HI;
                HP_LINE_HI: pos_next = HP_LINE_LO;
                HP_LINE_LO: pos_next = HP_OFF_HI;
                HP_OFF_HI:  pos_next = HP_OFF_LO;
                default:    pos_next = HP_LEN_HI;
            endcase
        end
        else
        begin
            pos_next = pos_reg;
        end

        if (byte_ch.kind)
        begin
            bidx_next = 16'd0;
            pos_next  = pos_reg;
            mk_next   = 1'b0;
            ts_next   = 32'd0;
            cnt_next  = '0;
            done_next = 1'b0;
            pend_next = 1'b0;
            ent_next  = ent_reg;
            we        = 1'b0;
            op        = '0;
            op.eos    = 1'b1;
            op.clear  = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bidx_reg <= '0;
            pos_reg  <= HP_LEN_HI;
            mk_reg   <= 1'b0;
            ts_reg   <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
            pend_reg <= 1'b0;
        end
        else if (accept)
        begin
            bidx_reg <= bidx_next;
            pos_reg  <= pos_next;
            mk_reg   <= mk_next;
            ts_reg   <= ts_next;
            cnt_reg  <= cnt_next;
            done_reg <= done_next;
            pend_reg <= pend_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            ent_reg <= ent_next;
        end
    end

endmodule

// ===== rtl/rvd_back.sv =====
module rvd_back
    import rvd_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32,
    parameter int FRAME_BYTES = 8388608,
    localparam int IDXW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1,
    localparam int CW = $clog2(MAX_SEGMENTS + 1)
)(
    input  logic            clk,
    input  logic            rst_n,
    input  logic [15:0]     stride,
    input  logic            pop_valid,
    output logic            pop_ready,
    input  seg_op_t         h,
    output logic [IDXW-1:0] tbl_raddr,
    input  seg_entry_t      tbl_rdata,
    rvd_result_if.source    result_ch
);

    back_state_t   st_reg, st_next;
    logic [CW-1:0] cur_reg, cur_next;
    logic [15:0]   left_reg, left_next;
    logic [22:0]   addr_reg, addr_next;
    logic          wr_reg, wr_next;
    logic          stop_reg, stop_next;
    logic [14:0]   hl_reg, hl_next;
    logic          fopen_reg, fopen_next;
    logic [31:0]   ots_reg, ots_next;
    seg_entry_t    ent_reg, ent_next;
    logic [30:0]   prod_reg, prod_next;
    logic          out_valid_reg, out_valid_next;
    result_t       out_reg, out_next;

    logic          slot;
    logic          pay_act, pay_wr, pay_last;
    logic          ts_new, ts_emit, eop_only;
    logic          run_go, eop_go;
    logic          rd_done, chk_over, chk_done;
    logic [15:0]   hl_plus;
    logic [31:0]   fprod;
    logic [30:0]   lprod;
    logic [32:0]   dest;
    logic          fits;

    function automatic result_t frame_word(logic [1:0] k, logic [30:0] size,
                                           logic [31:0] ts);
        result_t r;
        r      = '0;
        r.kind = k;
        r.size = size;
        r.ts   = ts;
        r.last = 1'b1;
        return r;
    endfunction

    assign slot      = !out_valid_reg || result_ch.ready;
    assign tbl_raddr = cur_reg[IDXW-1:0];

    assign pay_act  = h.payload && !stop_reg && (SEG_CNT_W'(cur_reg) < h.count) &&
                      (left_reg != 16'd0);
    assign pay_wr   = pay_act && wr_reg;
    assign pay_last = pay_act && (left_reg == 16'd1);
    assign ts_new   = h.ts_check && (!fopen_reg || (h.ts != ots_reg));
    assign ts_emit  = ts_new && fopen_reg;
    assign eop_only = h.eop && fopen_reg && !pay_last && !h.open && !pay_wr;
    assign run_go   = pop_valid && (!(h.eos || ts_emit || pay_wr || eop_only) || slot);
    assign eop_go   = !fopen_reg || slot;

    assign rd_done  = stop_reg || (SEG_CNT_W'(cur_reg) >= h.count);
    assign chk_over = ({1'b0, h.next_off} + {1'b0, ent_reg.len}) > {1'b0, h.plen};
    assign chk_done = chk_over || (ent_reg.len != 16'd0);

    assign hl_plus = {1'b0, hl_reg} + 16'd1;
    assign fprod   = stride * hl_plus;
    assign lprod   = 31'(tbl_rdata.line) * 31'(stride);
    assign dest    = {2'b00, prod_reg} + {17'd0, ent_reg.off, 1'b0};
    assign fits    = (dest + {17'd0, ent_reg.len}) <= 33'(FRAME_BYTES);

    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            BK_RUN:
            begin
                if (run_go)
                begin
                    if (pay_last || h.open)
                    begin
                        st_next = BK_OPEN_RD;
                    end
                    else if (pay_wr && h.eop && fopen_reg)
                    begin
                        st_next = BK_EOP;
                    end
                end
            end
            BK_OPEN_RD:
            begin
                if (rd_done)
                begin
                    st_next = h.eop ? BK_EOP : BK_RUN;
                end
                else
                begin
                    st_next = BK_OPEN_MUL;
                end
            end
            BK_OPEN_MUL: st_next = BK_OPEN_CHK;
            BK_OPEN_CHK:
            begin
                if (chk_done)
                begin
                    st_next = h.eop ? BK_EOP : BK_RUN;
                end
                else
                begin
                    st_next = BK_OPEN_RD;
                end
            end
            BK_EOP:
            begin
                if (eop_go)
                begin
                    st_next = BK_RUN;
                end
            end
            default: st_next = BK_RUN;
        endcase
    end

    always_comb
    begin
        cur_next       = cur_reg;
        left_next      = left_reg;
        addr_next      = addr_reg;
        wr_next        = wr_reg;
        stop_next      = stop_reg;
        hl_next        = hl_reg;
        fopen_next     = fopen_reg;
        ots_next       = ots_reg;
        ent_next       = ent_reg;
        prod_next      = prod_reg;
        out_valid_next = out_valid_reg && !result_ch.ready;
        out_next       = out_reg;
        pop_ready      = 1'b0;

        unique case (st_reg)
            BK_RUN:
            begin
                if (run_go)
                begin
                    pop_ready = !(pay_last || h.open) && !(pay_wr && h.eop && fopen_reg);
                    if (h.clear)
                    begin
                        cur_next  = '0;
                        left_next = 16'd0;
                        addr_next = 23'd0;
                        wr_next   = 1'b0;
                        stop_next = 1'b0;
                    end
                    if (h.eos)
                    begin
                        out_next       = frame_word(KIND_EOS, fprod[30:0], ots_reg);
                        out_valid_next = 1'b1;
                    end
                    else if (ts_new)
                    begin
                        if (fopen_reg)
                        begin
                            out_next       = frame_word(KIND_FRAME, fprod[30:0], ots_reg);
                            out_valid_next = 1'b1;
                        end
                        ots_next   = h.ts;
                        fopen_next = 1'b1;
                        hl_next    = 15'd0;
                    end
                    else if (pay_act)
                    begin
                        if (wr_reg)
                        begin
                            out_next       = '0;
                            out_next.kind  = KIND_WRITE;
                            out_next.addr  = addr_reg;
                            out_next.data  = h.data;
                            out_next.last  = !(h.eop && fopen_reg);
                            out_valid_next = 1'b1;
                        end
                        addr_next = addr_reg + 23'd1;
                        left_next = left_reg - 16'd1;
                        if (pay_last)
                        begin
                            cur_next = cur_reg + 1'b1;
                        end
                    end
                    if (eop_only)
                    begin
                        out_next       = frame_word(KIND_FRAME, fprod[30:0], ots_reg);
                        out_valid_next = 1'b1;
                        fopen_next     = 1'b0;
                    end
                end
            end
            BK_OPEN_RD:
            begin
                pop_ready = rd_done && !h.eop;
            end
            BK_OPEN_MUL:
            begin
                ent_next  = tbl_rdata;
                prod_next = lprod;
            end
            BK_OPEN_CHK:
            begin
                pop_ready = chk_done && !h.eop;
                if (chk_over)
                begin
                    stop_next = 1'b1;
                end
                else
                begin
                    if (ent_reg.line > hl_reg)
                    begin
                        hl_next = ent_reg.line;
                    end
                    wr_next   = fits;
                    addr_next = fits ? dest[22:0] : 23'd0;
                    left_next = ent_reg.len;
                    if (ent_reg.len == 16'd0)
                    begin
                        cur_next = cur_reg + 1'b1;
                    end
                end
            end
            BK_EOP:
            begin
                if (eop_go)
                begin
                    pop_ready = 1'b1;
                    if (fopen_reg)
                    begin
                        out_next       = frame_word(KIND_FRAME, fprod[30:0], ots_reg);
                        out_valid_next = 1'b1;
                        fopen_next     = 1'b0;
                    end
                end
            end
            default: pop_ready = 1'b0;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg        <= BK_RUN;
            cur_reg       <= '0;
            left_reg      <= '0;
            addr_reg      <= '0;
            wr_reg        <= 1'b0;
            stop_reg      <= 1'b0;
            hl_reg        <= '0;
            fopen_reg     <= 1'b0;
            ots_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            st_reg        <= st_next;
            cur_reg       <= cur_next;
            left_reg      <= left_next;
            addr_reg      <= addr_next;
            wr_reg        <= wr_next;
            stop_reg      <= stop_next;
            hl_reg        <= hl_next;
            fopen_reg     <= fopen_next;
            ots_reg       <= ots_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        ent_reg  <= ent_next;
        prod_reg <= prod_next;
        out_reg  <= out_next;
    end

    assign result_ch.valid           = out_valid_reg;
    assign result_ch.kind_res        = out_reg.kind;
    assign result_ch.write_address   = out_reg.addr;
    assign result_ch.write_data      = out_reg.data;
    assign result_ch.frame_size      = out_reg.size;
    assign result_ch.frame_timestamp = out_reg.ts;
    assign result_ch.last_of_run     = out_reg.last;

`ifndef SYNTHESIS
    a_chk_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_OPEN_CHK) |-> (SEG_CNT_W'(cur_reg) < h.count))
        else $error("segment check runs past the header count");
    a_eop_has_op: assert property (@(posedge clk) disable iff (!rst_n)
        (st_reg == BK_EOP) |-> (pop_valid && h.eop))
        else $error("end-of-packet state without a matching word");
    a_stop_idle: assert property (@(posedge clk) disable iff (!rst_n)
        stop_reg |-> (left_reg == 16'd0))
        else $error("payload stopped while a segment is still open");
`endif

endmodule

// ===== rtl/rtp_video_depacketizer.sv =====
// Channel    Role    Word                                         Handshake
// byte_ch    sink    kind, data_byte, packet_length               valid/ready
// result_ch  source  kind_res, write_address, write_data,         valid/ready
//                    frame_size, frame_timestamp, last_of_run
// apb        slave   line_stride_bytes at byte address 0          psel/penable
//
// Header and payload bytes are taken at one word per cycle while the queue has room.
// Opening segments takes a table read, a multiply and a range check per segment header,
// plus a further table read when the header list runs out before a nonempty segment.
// A frame-done word at the end of a packet that follows a write or a segment opening
// is sent from a separate end-of-packet state.
// The segment table has no reset and needs no clearing pass; control state clears on rst_n.
// A four-word queue lets the byte side run ahead while the result side is stalled.
module rtp_video_depacketizer
    import rvd_pkg::*;
#(
    parameter int MAX_SEGMENTS = 32,
    parameter int FRAME_BYTES = 8388608,
    parameter int DEFAULT_LINE_PIXELS = 1920
)(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         psel,
    input  logic         penable,
    input  logic         pwrite,
    input  logic [2:0]   paddr,
    input  logic [31:0]  pwdata,
    output logic [31:0]  prdata,
    output logic         pready,
    rvd_byte_if.sink     byte_ch,
    rvd_result_if.source result_ch
);

    localparam int IDXW = (MAX_SEGMENTS > 1) ? $clog2(MAX_SEGMENTS) : 1;
    localparam logic [15:0] DEF_STRIDE = 16'(DEFAULT_LINE_PIXELS * 2);

    logic [15:0]     stride_reg;
    logic [15:0]     stride;
    logic            push_valid, push_ready;
    seg_op_t         push_op;
    logic            pop_valid, pop_ready;
    seg_op_t         pop_op;
    logic            tbl_we;
    logic [IDXW-1:0] tbl_waddr, tbl_raddr;
    seg_entry_t      tbl_wdata, tbl_rdata;

    assign pready = 1'b1;
    assign prdata = (paddr[2] == REG_LINE_STRIDE) ? {16'd0, stride_reg} : 32'd0;
    assign stride = (stride_reg == 16'd0) ? DEF_STRIDE : stride_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            stride_reg <= '0;
        end
        else if (psel && penable && pwrite && (paddr[2] == REG_LINE_STRIDE))
        begin
            stride_reg <= pwdata[15:0];
        end
    end

    rvd_front #(
        .MAX_SEGMENTS(MAX_SEGMENTS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .byte_ch   (byte_ch),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_op   (push_op),
        .tbl_we    (tbl_we),
        .tbl_waddr (tbl_waddr),
        .tbl_wdata (tbl_wdata)
    );

    rvd_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push_valid(push_valid),
        .push_ready(push_ready),
        .push_op   (push_op),
        .pop_valid (pop_valid),
        .pop_ready (pop_ready),
        .pop_op    (pop_op)
    );

    rvd_ram #(
        .WIDTH($bits(seg_entry_t)),
        .DEPTH(MAX_SEGMENTS)
    ) u_table (
        .clk  (clk),
        .we   (tbl_we),
        .waddr(tbl_waddr),
        .wdata(tbl_wdata),
        .raddr(tbl_raddr),
        .rdata(tbl_rdata)
    );

    rvd_back #(
        .MAX_SEGMENTS(MAX_SEGMENTS),
        .FRAME_BYTES (FRAME_BYTES)
    ) u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .stride   (stride),
        .pop_valid(pop_valid),
        .pop_ready(pop_ready),
        .h        (pop_op),
        .tbl_raddr(tbl_raddr),
        .tbl_rdata(tbl_rdata),
        .result_ch(result_ch)
    );

endmodule

// ===== tb/tb_rtp_video_depacketizer.sv =====
`timescale 1ns / 1ps

module tb_rtp_video_depacketizer;
    import rvd_pkg::*;

    localparam int SEGS      = 32;
    localparam longint FRAME = 8388608;
    localparam int LIMIT     = 900000;

    typedef struct {
        logic        kind;
        logic [7:0]  data;
        logic [15:0] plen;
    } byte_word_t;

    logic        clk;
    logic        rst_n;
    logic        psel;
    logic        penable;
    logic        pwrite;
    logic [2:0]  paddr;
    logic [31:0] pwdata;
    logic [31:0] prdata;
    logic        pready;

    rvd_byte_if   byte_bus ();
    rvd_result_if res_bus ();

    rtp_video_depacketizer u_top (
        .clk       (clk),
        .rst_n     (rst_n),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready),
        .byte_ch   (byte_bus),
        .result_ch (res_bus)
    );

    byte_word_t  pending_q[$];
    result_t     frame_q[$];

    // Predictor state of the depacketizer.
    int unsigned cfg_stride;
    int unsigned byte_idx;
    bit          mk_seen;
    logic [31:0] ts_acc;
    logic [31:0] open_ts;
    bit          frm_open;
    int unsigned hi_line;
    int unsigned seg_len [SEGS];
    int unsigned seg_line [SEGS];
    int unsigned seg_off [SEGS];
    int unsigned seg_cnt;
    bit          hdr_done;
    int unsigned cursor;
    int unsigned bytes_left;
    longint      nxt_addr;
    bit          writable;
    bit          stopped;

    int          errors;
    int          words_sent;
    int          results_seen;
    int          frames_seen;
    int          cycles;
    bit          took;
    int          gap_cnt;
    int          stall_cnt;
    bit          send_burst;
    bit          recv_burst;

    function automatic int unsigned stride_now();
        return (cfg_stride != 0) ? cfg_stride : 1920 * 2;
    endfunction

    function automatic logic [30:0] size_now();
        longint unsigned s;
        s = longint'(stride_now()) * (hi_line + 1);
        return s[30:0];
    endfunction

    task automatic emit(input logic [1:0] k, input logic [22:0] a, input logic [7:0] d,
                        input logic [30:0] sz, input logic [31:0] ts);
        result_t r;
        r.kind = k;
        r.addr = a;
        r.data = d;
        r.size = sz;
        r.ts   = ts;
        r.last = 1'b0;
        frame_q.push_back(r);
    endtask

    task automatic clear_packet();
        mk_seen    = 0;
        ts_acc     = '0;
        seg_cnt    = 0;
        hdr_done   = 0;
        cursor     = 0;
        bytes_left = 0;
        nxt_addr   = 0;
        writable   = 0;
        stopped    = 0;
    endtask

    task automatic open_segments(input int unsigned next_off, input int unsigned plen);
        int unsigned i;
        int unsigned len;
        longint      dest;
        while (!stopped && cursor < seg_cnt && cursor < SEGS) begin
            i = cursor;
            len = seg_len[i];
            if (longint'(next_off) + len > plen) begin
                stopped = 1;
                break;
            end
            if (seg_line[i] > hi_line)
                hi_line = seg_line[i];
            dest = longint'(seg_line[i]) * stride_now() + longint'(seg_off[i]) * 2;
            writable = (dest + len) <= FRAME;
            nxt_addr = writable ? dest : 0;
            bytes_left = len;
            if (len != 0)
                break;
            cursor++;
        end
    endtask

    task automatic predict_word(input byte_word_t w);
        int unsigned b;
        int unsigned plen;
        int unsigned pos;
        int unsigned e;
        int          n0;
        n0 = frame_q.size();
        b = byte_idx;
        plen = w.plen;
        if (w.kind) begin
            emit(KIND_EOS, '0, '0, size_now(), open_ts);
            byte_idx = 0;
            clear_packet();
        end
        else begin
            if (b == 0)
                clear_packet();
            if (plen >= 20) begin
                if (b == 1)
                    mk_seen = w.data[7];
                if (b >= 4 && b <= 7)
                    ts_acc = {ts_acc[23:0], w.data};
                if (b == 7 && (!frm_open || ts_acc != open_ts)) begin
                    if (frm_open)
                        emit(KIND_FRAME, '0, '0, size_now(), open_ts);
                    open_ts = ts_acc;
                    frm_open = 1;
                    hi_line = 0;
                end
                if (b >= 14 && !hdr_done) begin
                    pos = (b - 14) % 6;
                    if (pos == 0 && seg_cnt < SEGS) begin
                        seg_len[seg_cnt] = 0;
                        seg_line[seg_cnt] = 0;
                        seg_off[seg_cnt] = 0;
                        seg_cnt++;
                    end
                    e = (seg_cnt != 0) ? seg_cnt - 1 : 0;
                    case (pos)
                        0: seg_len[e] = w.data << 8;
                        1: seg_len[e] |= w.data;
                        2: seg_line[e] = w.data[6:0] << 8;
                        3: seg_line[e] |= w.data;
                        4:
                        begin
                            seg_off[e] = w.data[6:0] << 8;
                            if (!w.data[7])
                                hdr_done = 1;
                        end
                        default:
                        begin
                            seg_off[e] |= w.data;
                            if (hdr_done || seg_cnt >= SEGS || b + 7 > plen) begin
                                hdr_done = 1;
                                open_segments(b + 1, plen);
                            end
                        end
                    endcase
                end
                else if (b >= 14 && hdr_done) begin
                    if (((b - 14) % 6) != 0 && b < 14 + 6 * seg_cnt) begin
                        e = (seg_cnt != 0) ? seg_cnt - 1 : 0;
                        seg_off[e] |= w.data;
                        open_segments(b + 1, plen);
                    end
                    else if (!stopped && cursor < seg_cnt && bytes_left > 0) begin
                        if (writable)
                            emit(KIND_WRITE, nxt_addr[22:0], w.data, '0, '0);
                        nxt_addr++;
                        bytes_left--;
                        if (bytes_left == 0) begin
                            cursor++;
                            open_segments(b + 1, plen);
                        end
                    end
                end
            end
            if (b + 1 >= plen) begin
                if (plen >= 20 && mk_seen && frm_open) begin
                    emit(KIND_FRAME, '0, '0, size_now(), open_ts);
                    frm_open = 0;
                end
                byte_idx = 0;
            end
            else begin
                byte_idx = (b + 1) & 16'hFFFF;
            end
        end
        if (frame_q.size() > n0)
            frame_q[frame_q.size() - 1].last = 1'b1;
    endtask

    task automatic push_word(input logic k, input logic [7:0] d, input logic [15:0] plen);
        byte_word_t w;
        w.kind = k;
        w.data = d;
        w.plen = plen;
        pending_q.push_back(w);
    endtask

    task automatic push_bytes(ref logic [7:0] pkt[$], input logic [15:0] plen);
        foreach (pkt[i])
            push_word(1'b0, pkt[i], plen);
    endtask

    // Builds one RTP packet with random segment headers and payload.
    task automatic push_packet(input bit marker, input logic [31:0] ts);
        logic [7:0]  pkt[$];
        int unsigned nseg;
        int unsigned len;
        int unsigned line;
        int unsigned off;
        bit          cont;
        int unsigned total;
        int unsigned cut;
        nseg = ($urandom_range(0, 19) == 0) ? $urandom_range(30, 34) : $urandom_range(1, 4);
        pkt.push_back(8'h80);
        pkt.push_back({marker, 7'($urandom)});
        for (int i = 0; i < 2; i++)
            pkt.push_back(8'($urandom));
        for (int i = 3; i >= 0; i--)
            pkt.push_back(ts[i*8 +: 8]);
        for (int i = 0; i < 6; i++)
            pkt.push_back(8'($urandom));
        total = 0;
        for (int i = 0; i < nseg; i++) begin
            len = (nseg > 8) ? $urandom_range(0, 1) : $urandom_range(0, 24);
            line = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 40);
            off = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 32767) : $urandom_range(0, 64);
            cont = (i < nseg - 1);
            if ($urandom_range(0, 9) == 0)
                cont = !cont;
            total += len;
            pkt.push_back(len[15:8]);
            pkt.push_back(len[7:0]);
            pkt.push_back({$urandom_range(0, 1) == 1, line[14:8]});
            pkt.push_back(line[7:0]);
            pkt.push_back({cont, off[14:8]});
            pkt.push_back(off[7:0]);
        end
        total += $urandom_range(0, 3);
        for (int i = 0; i < total; i++)
            pkt.push_back(8'($urandom));
        while (pkt.size() < 20)
            pkt.push_back(8'($urandom));
        if ($urandom_range(0, 9) == 0) begin
            cut = $urandom_range(20, pkt.size());
            while (pkt.size() > cut)
                void'(pkt.pop_back());
        end
        push_bytes(pkt, 16'(pkt.size()));
    endtask

    task automatic apb_write(input logic [31:0] value);
        @(negedge clk);
        psel <= 1'b1;
        pwrite <= 1'b1;
        paddr <= 3'(4 * REG_LINE_STRIDE);
        pwdata <= value;
        @(negedge clk);
        penable <= 1'b1;
        @(negedge clk);
        psel <= 1'b0;
        penable <= 1'b0;
        pwrite <= 1'b0;
        cfg_stride = value[15:0];
    endtask

    task automatic wait_idle();
        wait (pending_q.size() == 0 && !byte_bus.valid && frame_q.size() == 0);
        repeat (30) @(posedge clk);
    endtask

    initial begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    always @(posedge clk) begin
        cycles <= cycles + 1;
        if (cycles > LIMIT) begin
            $display("timeout after %0d cycles, %0d results still expected",
                     cycles, frame_q.size());
            $display("[rtp_video_depacketizer] ERROR");
            $finish;
        end
    end

    // Byte side: acceptance and prediction at the rising edge, driving at the falling edge.
    always @(posedge clk) begin
        took <= byte_bus.valid && byte_bus.ready;
        if (rst_n && byte_bus.valid && byte_bus.ready) begin
            predict_word('{byte_bus.kind, byte_bus.data_byte, byte_bus.packet_length});
            words_sent <= words_sent + 1;
        end
    end

    always @(negedge clk) begin
        byte_word_t w;
        if (rst_n && !(byte_bus.valid && !took)) begin
            if ($urandom_range(0, 199) == 0)
                send_burst = !send_burst;
            if (gap_cnt > 0) begin
                gap_cnt--;
                byte_bus.valid <= 1'b0;
            end
            else if (pending_q.size() != 0) begin
                w = pending_q.pop_front();
                byte_bus.valid <= 1'b1;
                byte_bus.kind <= w.kind;
                byte_bus.data_byte <= w.data;
                byte_bus.packet_length <= w.plen;
                gap_cnt = send_burst ? 0 : $urandom_range(0, 14);
            end
            else begin
                byte_bus.valid <= 1'b0;
            end
        end
    end

    // Result side.
    always @(negedge clk) begin
        if (rst_n) begin
            if ($urandom_range(0, 199) == 0)
                recv_burst = !recv_burst;
            if (stall_cnt > 0) begin
                stall_cnt--;
                res_bus.ready <= 1'b0;
            end
            else begin
                res_bus.ready <= 1'b1;
                if (res_bus.valid && res_bus.ready)
                    stall_cnt = recv_burst ? 0 : $urandom_range(0, 14);
            end
        end
    end

    always @(posedge clk) begin
        result_t x;
        if (rst_n && res_bus.valid && res_bus.ready) begin
            results_seen <= results_seen + 1;
            if (frame_q.size() == 0) begin
                errors++;
                if (errors <= 10)
                    $display("unexpected result word: kind %0d addr %0h", res_bus.kind_res,
                             res_bus.write_address);
            end
            else begin
                x = frame_q.pop_front();
                if (x.kind != KIND_WRITE)
                    frames_seen <= frames_seen + 1;
                if (res_bus.kind_res !== x.kind || res_bus.write_address !== x.addr ||
                    res_bus.write_data !== x.data || res_bus.frame_size !== x.size ||
                    res_bus.frame_timestamp !== x.ts || res_bus.last_of_run !== x.last) begin
                    errors++;
                    if (errors <= 10) begin
                        $write("mismatch: expected kind %0d addr %0h data %0h size %0d ",
                               x.kind, x.addr, x.data, x.size);
                        $write("ts %0h last %0d, ", x.ts, x.last);
                        $display("got %0d %0h %0h %0d %0h %0d",
                                 res_bus.kind_res, res_bus.write_address, res_bus.write_data,
                                 res_bus.frame_size, res_bus.frame_timestamp,
                                 res_bus.last_of_run);
                    end
                end
            end
        end
    end

    initial begin
        logic [31:0] strides [5];
        logic [31:0] ts;
        logic [7:0]  pkt[$];
        int          target;
        rst_n = 1'b0;
        psel = 1'b0;
        penable = 1'b0;
        pwrite = 1'b0;
        paddr = '0;
        pwdata = '0;
        byte_bus.valid = 1'b0;
        byte_bus.kind = 1'b0;
        byte_bus.data_byte = '0;
        byte_bus.packet_length = '0;
        res_bus.ready = 1'b0;
        errors = 0;
        words_sent = 0;
        results_seen = 0;
        frames_seen = 0;
        cycles = 0;
        took = 0;
        gap_cnt = 0;
        stall_cnt = 0;
        send_burst = 0;
        recv_burst = 0;
        cfg_stride = 0;
        byte_idx = 0;
        open_ts = '0;
        frm_open = 0;
        hi_line = 0;
        clear_packet();
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // Directed: end of stream with nothing open, a zero-length and a one-byte packet,
        // a minimal packet with the marker and a zero-length segment, then end of stream.
        push_word(1'b1, 8'hFF, 16'hFFFF);
        push_word(1'b0, 8'hFF, 16'd0);
        push_word(1'b0, 8'h00, 16'd1);
        pkt = '{8'h80, 8'h80, 8'h00, 8'h01, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 8'h00, 8'h00,
                8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h00, 8'h7F, 8'hFF, 8'h7F, 8'hFF};
        push_bytes(pkt, 16'd20);
        pkt.delete();
        push_word(1'b1, 8'h00, 16'd0);
        wait_idle();

        strides = '{32'd0, 32'd65535, 32'd1, 32'($urandom_range(2, 65534)), 32'd3840};
        ts = $urandom;
        foreach (strides[p]) begin
            apb_write(strides[p]);
            target = words_sent + pending_q.size() + 340;
            while (words_sent + pending_q.size() < target) begin
                if ($urandom_range(0, 2) == 0)
                    ts = $urandom;
                case ($urandom_range(0, 19))
                    0:
                    begin
                        repeat ($urandom_range(1, 4))
                            push_word(1'($urandom), 8'($urandom), 16'($urandom));
                        push_word(1'b1, 8'($urandom), 16'($urandom));
                    end
                    1:
                    begin
                        repeat ($urandom_range(1, 19))
                            pkt.push_back(8'($urandom));
                        push_bytes(pkt, 16'(pkt.size()));
                        pkt.delete();
                    end
                    2: push_word(1'b1, 8'($urandom), 16'($urandom));
                    default: push_packet($urandom_range(0, 3) == 0, ts);
                endcase
            end
            push_word(1'b1, 8'h00, 16'd0);
            wait_idle();
        end

        $display("sent %0d words over five stride settings, checked %0d results",
                 words_sent, results_seen);
        $display("of which %0d were frame or end-of-stream reports", frames_seen);
        if (errors == 0)
            $display("[rtp_video_depacketizer] OK");
        else
            $display("[rtp_video_depacketizer] ERROR");
        $finish;
    end

endmodule

// ===== filelist.f =====
rtl/rvd_pkg.sv
rtl/rvd_if.sv
rtl/rvd_ram.sv
rtl/rvd_queue.sv
rtl/rvd_front.sv
rtl/rvd_back.sv
rtl/rtp_video_depacketizer.sv
tb/tb_rtp_video_depacketizer.sv
